[rtl/core/jdvm_pkg.sv]
// Shared types, constants and helpers for the joystick deadzone velocity mapper.
package jdvm_pkg;

  localparam int AXIS_COUNT  = 8;
  localparam int VALUE_WIDTH = 16;
  localparam int AXIS_IDX_W  = $clog2(AXIS_COUNT);

  localparam int NUM_W       = 8;
  localparam int IN_FIELDS_W = NUM_W + VALUE_WIDTH;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int RES_W       = 25;
  localparam int OUT_FIELDS_W = 3 * RES_W;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int LIMIT_W     = 24;

  // normalised magnitude: Q1.16, 17 bits
  localparam int MAG_W       = 17;
  localparam int NORM_W      = VALUE_WIDTH + 16;
  localparam int PROD_W      = MAG_W + LIMIT_W;

  localparam logic [4:0]        BITS_MIN   = 5'd2;
  localparam logic [4:0]        BITS_MAX   = 5'd30;
  localparam logic [4:0]        NORM_POINT = 5'd17;
  localparam logic [MAG_W-1:0]  ONE_Q16    = 17'h10000;
  localparam logic [15:0]       DZ_MAX     = 16'd62259;

  // divider: four quotient bits a cycle, 20 quotient bits in all
  localparam int DIV_RADIX   = 4;
  localparam int DIV_STEPS   = 5;
  localparam int DIV_Q_W     = DIV_RADIX * DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [1:0] LAYOUT_012 = 2'd0;
  localparam logic [1:0] LAYOUT_013 = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_BITS = 3'd0,
    REG_DEADZONE  = 3'd1,
    REG_LAYOUT    = 3'd2,
    REG_FWD_LIMIT = 3'd3,
    REG_LAT_LIMIT = 3'd4,
    REG_TURN_LIMIT = 3'd5,
    REG_SIGN_MASK = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]         axis_bits;
    logic [15:0]        deadzone;
    logic [1:0]         layout;
    logic [LIMIT_W-1:0] fwd_limit;
    logic [LIMIT_W-1:0] lat_limit;
    logic [LIMIT_W-1:0] turn_limit;
    logic [2:0]         sign_mask;
  } cfg_t;

  typedef enum logic [1:0] {
    SLOT_FWD  = 2'd0,
    SLOT_LAT  = 2'd1,
    SLOT_TURN = 2'd2
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic  store_wr;
    logic  load;
    logic  div_step;
    logic  mul;
    logic  sat;
    logic  out_load;
    slot_t slot;
  } cmd_t;

  typedef struct packed {
    logic in_is_read;
    logic in_store_ok;
    logic layout_on;
    logic out_busy;
  } sts_t;

  // table index of the axis feeding a command slot
  function automatic logic [AXIS_IDX_W-1:0] layout_axis(logic [1:0] layout, slot_t slot);
    logic [AXIS_IDX_W-1:0] idx;
    case (slot)
      SLOT_FWD:  idx = AXIS_IDX_W'(1);
      SLOT_LAT:  idx = AXIS_IDX_W'(0);
      SLOT_TURN: idx = (layout == LAYOUT_013) ? AXIS_IDX_W'(3) : AXIS_IDX_W'(2);
      default:   idx = AXIS_IDX_W'(0);
    endcase
    return idx;
  endfunction

endpackage

[rtl/core/jdvm_cfg.sv]
// Configuration register file of the joystick deadzone velocity mapper.
module jdvm_cfg
  import jdvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_AXIS_BITS:  cfg_nxt.axis_bits  = cfg_wdata[4:0];
        REG_DEADZONE:   cfg_nxt.deadzone   = cfg_wdata[15:0];
        REG_LAYOUT:     cfg_nxt.layout     = cfg_wdata[1:0];
        REG_FWD_LIMIT:  cfg_nxt.fwd_limit  = cfg_wdata[LIMIT_W-1:0];
        REG_LAT_LIMIT:  cfg_nxt.lat_limit  = cfg_wdata[LIMIT_W-1:0];
        REG_TURN_LIMIT: cfg_nxt.turn_limit = cfg_wdata[LIMIT_W-1:0];
        REG_SIGN_MASK:  cfg_nxt.sign_mask  = cfg_wdata[2:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_bits  <= 5'd16;
      cfg_r.deadzone   <= '0;
      cfg_r.layout     <= 2'd2;
      cfg_r.fwd_limit  <= '0;
      cfg_r.lat_limit  <= '0;
      cfg_r.turn_limit <= '0;
      cfg_r.sign_mask  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/jdvm_ctrl.sv]
// Sequencing state machine: axis stores, per-axis load, divide, multiply, saturate, output.
module jdvm_ctrl
  import jdvm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  st_t                  state_r, state_nxt;
  slot_t                slot_r, slot_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && sts.in_is_read && sts.layout_on) begin
          state_nxt = ST_LOAD;
          slot_nxt  = SLOT_FWD;
        end
      end
      ST_LOAD: begin
        state_nxt   = ST_DIV;
        div_cnt_nxt = '0;
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      ST_MUL: state_nxt = ST_SAT;
      ST_SAT: begin
        case (slot_r)
          SLOT_FWD: begin
            slot_nxt  = SLOT_LAT;
            state_nxt = ST_LOAD;
          end
          SLOT_LAT: begin
            slot_nxt  = SLOT_TURN;
            state_nxt = ST_LOAD;
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.slot     = slot_r;
    in_tready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.store_wr = in_tvalid && !sts.in_is_read && sts.in_store_ok;
      end
      ST_LOAD: cmd.load     = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_SAT:  cmd.sat      = 1'b1;
      ST_OUT:  cmd.out_load = !sts.out_busy;
      default: cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      slot_r    <= SLOT_FWD;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.store_wr, cmd.load, cmd.div_step, cmd.mul, cmd.sat, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r < DIV_CNT_W'(DIV_STEPS)))
    else $error("divide step count overran");

  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r == SLOT_FWD) || (slot_r == SLOT_LAT) || (slot_r == SLOT_TURN))
    else $error("command slot out of range");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after output load");

  a_sat_turn: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sat && (slot_r == SLOT_TURN)) |=> (state_r == ST_OUT))
    else $error("last axis did not lead to output");
`endif

endmodule

[rtl/core/jdvm_dp.sv]
// Datapath: axis table, normaliser, radix-16 divider, limit multiplier and output register.
module jdvm_dp
  import jdvm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   in_tuser,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata
);

  logic [NUM_W-1:0]             in_number;
  logic signed [VALUE_WIDTH-1:0] in_value;

  logic signed [VALUE_WIDTH-1:0] store_r [AXIS_COUNT];

  // per-axis load
  logic [AXIS_IDX_W-1:0]  pick_idx;
  logic [VALUE_WIDTH-1:0] raw;
  logic                   raw_neg;
  logic [VALUE_WIDTH:0]   raw_ext;
  logic [VALUE_WIDTH:0]   mag;
  logic [4:0]             bits_c;
  logic [NORM_W-1:0]      mag_sh;
  logic [MAG_W-1:0]       norm;
  logic [15:0]            dz_c;
  logic [MAG_W-1:0]       diff;
  logic                   slot_sign;

  // divider
  logic [MAG_W-1:0]   div_d_r;
  logic [15:0]        rem_r, rem_nxt;
  logic [DIV_Q_W-1:0] num_r, num_nxt;
  logic [DIV_Q_W-1:0] q_r, q_nxt;
  logic               neg_r;

  logic [LIMIT_W-1:0] limit_sel;
  logic [PROD_W-1:0]  prod_r;
  logic [RES_W-1:0]   v_trunc;
  logic [RES_W-1:0]   lim_ext;
  logic [RES_W-1:0]   v_sat;
  logic [RES_W-1:0]   res_r [3];

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign in_number = in_tdata[NUM_W-1:0];
  assign in_value  = in_tdata[NUM_W +: VALUE_WIDTH];

  assign sts.in_is_read  = in_tuser;
  assign sts.in_store_ok = (in_number < NUM_W'(AXIS_COUNT));
  assign sts.layout_on   = (cfg.layout == LAYOUT_012) || (cfg.layout == LAYOUT_013);
  assign sts.out_busy    = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        store_r[i] <= '0;
      end
    end else if (cmd.store_wr) begin
      store_r[in_number[AXIS_IDX_W-1:0]] <= in_value;
    end
  end

  // normalise to Q1.16, clamp, take off the deadzone
  always_comb begin
    pick_idx = layout_axis(cfg.layout, cmd.slot);
    raw      = store_r[pick_idx];
    raw_neg  = raw[VALUE_WIDTH-1];
    raw_ext  = {raw[VALUE_WIDTH-1], raw};
    mag      = raw_neg ? (~raw_ext + 1'b1) : raw_ext;
    if (cfg.axis_bits < BITS_MIN) begin
      bits_c = BITS_MIN;
    end else if (cfg.axis_bits > BITS_MAX) begin
      bits_c = BITS_MAX;
    end else begin
      bits_c = cfg.axis_bits;
    end
    if (bits_c <= NORM_POINT) begin
      mag_sh = NORM_W'(mag) << (NORM_POINT - bits_c);
    end else begin
      mag_sh = NORM_W'(mag) >> (bits_c - NORM_POINT);
    end
    norm = (mag_sh > NORM_W'(ONE_Q16)) ? ONE_Q16 : mag_sh[MAG_W-1:0];
    dz_c = (cfg.deadzone > DZ_MAX) ? DZ_MAX : cfg.deadzone;
    diff = (norm > {1'b0, dz_c}) ? (norm - {1'b0, dz_c}) : '0;
    case (cmd.slot)
      SLOT_FWD:  slot_sign = cfg.sign_mask[0];
      SLOT_LAT:  slot_sign = cfg.sign_mask[1];
      SLOT_TURN: slot_sign = cfg.sign_mask[2];
      default:   slot_sign = 1'b0;
    endcase
  end

  // four restoring steps a cycle; remainder stays below the divisor
  always_comb begin
    logic [MAG_W-1:0] t;
    rem_nxt = rem_r;
    num_nxt = num_r;
    q_nxt   = q_r;
    for (int k = 0; k < DIV_RADIX; k++) begin
      t       = {rem_nxt, num_nxt[DIV_Q_W-1]};
      num_nxt = {num_nxt[DIV_Q_W-2:0], 1'b0};
      if (t >= div_d_r) begin
        rem_nxt = 16'(t - div_d_r);
        q_nxt   = {q_nxt[DIV_Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = t[15:0];
        q_nxt   = {q_nxt[DIV_Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_d_r <= ONE_Q16 - {1'b0, dz_c};
      rem_r   <= 16'(diff[MAG_W-1:DIV_RADIX]);
      num_r   <= {diff[DIV_RADIX-1:0], (DIV_Q_W - DIV_RADIX)'(0)};
      q_r     <= '0;
      neg_r   <= raw_neg ^ (cmd.slot == SLOT_FWD) ^ slot_sign;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      q_r   <= q_nxt;
    end
  end

  always_comb begin
    case (cmd.slot)
      SLOT_FWD:  limit_sel = cfg.fwd_limit;
      SLOT_LAT:  limit_sel = cfg.lat_limit;
      SLOT_TURN: limit_sel = cfg.turn_limit;
      default:   limit_sel = '0;
    endcase
    v_trunc = prod_r[PROD_W-1:16];
    lim_ext = {1'b0, limit_sel};
    v_sat   = (v_trunc > lim_ext) ? lim_ext : v_trunc;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(q_r[MAG_W-1:0]) * PROD_W'(limit_sel);
    end
    if (cmd.sat) begin
      res_r[cmd.slot] <= neg_r ? (~v_sat + 1'b1) : v_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OUT_DATA_W'({res_r[SLOT_TURN], res_r[SLOT_LAT], res_r[SLOT_FWD]});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/core/joystick_deadzone_velocity_map.sv]
// An axis event is taken while idle; a read request runs the three axes in turn through one shared
// divider (four quotient bits a cycle) and one 17x24 limit multiplier, and no new request is taken
// until its result has gone into the output register.
// Axis events go into the table at one a cycle while the block is idle.
// Reset (rst_n low, synchronous): axis table cleared, registers to defaults
// (axis_bits 16, layout disabled, all else zero), output empty.
module joystick_deadzone_velocity_map
  import jdvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] axis_number, [23:8] axis_value
  input  logic                  in_tuser,   // [0] func: 0 axis event, 1 read request
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [24:0] forward_velocity,
                                            // [49:25] lateral_velocity,
                                            // [74:50] turn_rate, rest zero
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // register file; to be written only while idle, which the block itself does not enforce
  jdvm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // controller: takes a request only in idle, steps the three command slots
  // (forward from the inverted second axis, lateral, yaw) through load,
  // divide, multiply and saturate, then waits for the output register
  jdvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: the output register parts the two channels, so the next request
  // is taken while a finished result still waits downstream
  jdvm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[tb/jdvm_velocity_checker.sv]
`timescale 1ns / 100ps
// Checker for the joystick mapper: mirrors table and registers, predicts and compares commands.
module jdvm_velocity_checker
  import jdvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic [RES_W-1:0] forward;
    logic [RES_W-1:0] lateral;
    logic [RES_W-1:0] turn;
  } velocity_cmd_t;

  velocity_cmd_t                 expected_cmds[$];
  logic signed [VALUE_WIDTH-1:0] axis_table[AXIS_COUNT];
  cfg_t                          regs;

  task automatic report(string what, logic [RES_W-1:0] want, logic [RES_W-1:0] got);
    $display("%0t mismatch: %s expected %h got %h", $time, what, want, got);
    fail_count++;
  endtask

  // normalise, deadzone, scale by limit and saturate; sign applied last
  function automatic logic [RES_W-1:0] axis_command(logic signed [VALUE_WIDTH-1:0] raw,
                                                   logic invert, logic [LIMIT_W-1:0] limit,
                                                   logic negate);
    longint      r;
    logic [63:0] mag;
    logic [63:0] vel;
    logic [63:0] neg_vel;
    logic        neg;
    logic [4:0]  bits;
    logic [15:0] dz;
    r    = longint'(raw);
    neg  = r < 0;
    mag  = neg ? 64'(-r) : 64'(r);
    bits = regs.axis_bits;
    if (bits < BITS_MIN) bits = BITS_MIN;
    if (bits > BITS_MAX) bits = BITS_MAX;
    dz = (regs.deadzone > DZ_MAX) ? DZ_MAX : regs.deadzone;
    if (bits <= NORM_POINT) mag = mag << (NORM_POINT - bits);
    else mag = mag >> (bits - NORM_POINT);
    if (mag > 64'(ONE_Q16)) mag = 64'(ONE_Q16);
    neg = neg ^ invert;
    if (mag <= 64'(dz)) mag = '0;
    else mag = (mag - 64'(dz)) * 64'(ONE_Q16) / (64'(ONE_Q16) - 64'(dz));
    vel = (mag * 64'(limit)) >> 16;
    if (vel > 64'(limit)) vel = 64'(limit);
    neg_vel = 64'd0 - vel;
    return (neg != negate) ? neg_vel[RES_W-1:0] : vel[RES_W-1:0];
  endfunction

  function automatic velocity_cmd_t predict_velocity();
    velocity_cmd_t         cmd;
    logic [AXIS_IDX_W-1:0] yaw_axis;
    yaw_axis    = (regs.layout == LAYOUT_013) ? AXIS_IDX_W'(3) : AXIS_IDX_W'(2);
    cmd.forward = axis_command(axis_table[1], 1'b1, regs.fwd_limit, regs.sign_mask[0]);
    cmd.lateral = axis_command(axis_table[0], 1'b0, regs.lat_limit, regs.sign_mask[1]);
    cmd.turn    = axis_command(axis_table[yaw_axis], 1'b0, regs.turn_limit,
                               regs.sign_mask[2]);
    return cmd;
  endfunction

  always @(posedge clk) begin : monitor
    velocity_cmd_t want;
    velocity_cmd_t got;
    logic [7:0]    num;
    if (!rst_n) begin
      foreach (axis_table[i]) axis_table[i] = '0;
      regs            = '0;
      regs.axis_bits  = 5'd16;
      regs.layout     = 2'd2;
      expected_cmds.delete();
      fail_count      = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_AXIS_BITS:  regs.axis_bits  = cfg_wdata[4:0];
          REG_DEADZONE:   regs.deadzone   = cfg_wdata[15:0];
          REG_LAYOUT:     regs.layout     = cfg_wdata[1:0];
          REG_FWD_LIMIT:  regs.fwd_limit  = cfg_wdata[LIMIT_W-1:0];
          REG_LAT_LIMIT:  regs.lat_limit  = cfg_wdata[LIMIT_W-1:0];
          REG_TURN_LIMIT: regs.turn_limit = cfg_wdata[LIMIT_W-1:0];
          REG_SIGN_MASK:  regs.sign_mask  = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (!in_tuser) begin
          num = in_tdata[7:0];
          if (num < AXIS_COUNT) axis_table[num[AXIS_IDX_W-1:0]] = in_tdata[23:8];
        end else if (regs.layout == LAYOUT_012 || regs.layout == LAYOUT_013) begin
          expected_cmds.push_back(predict_velocity());
        end
      end
      if (out_tvalid && out_tready) begin
        got.forward = out_tdata[RES_W-1:0];
        got.lateral = out_tdata[2*RES_W-1:RES_W];
        got.turn    = out_tdata[3*RES_W-1:2*RES_W];
        if (expected_cmds.size() == 0) begin
          report("result with nothing pending, forward", '0, got.forward);
        end else begin
          want = expected_cmds.pop_front();
          if (got.forward !== want.forward) report("forward_velocity", want.forward, got.forward);
          if (got.lateral !== want.lateral) report("lateral_velocity", want.lateral, got.lateral);
          if (got.turn !== want.turn) report("turn_rate", want.turn, got.turn);
        end
      end
    end
    outstanding <= expected_cmds.size();
  end

endmodule

[tb/joystick_deadzone_velocity_map_test.sv]
`timescale 1ns / 100ps
// Top of the joystick mapper test: clock, reset, request and register stimulus, verdict.
module joystick_deadzone_velocity_map_test;
  import jdvm_pkg::*;

  // request kinds carried on in_tuser
  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // layout codes with no axis set behind them
  localparam logic [1:0] LAYOUT_OFF      = 2'd2;
  localparam logic [1:0] LAYOUT_RESERVED = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_FULL = 24'hFFFFFF;

  // give a read margin to finish before touching registers
  localparam int SETTLE_CYCLES  = 40;
  // no accepted request for this long means the block is stuck
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 103;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // [7:0] axis_number, [23:8] axis_value
  logic                  in_tuser;    // [0] func
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // [24:0] forward, [49:25] lateral, [74:50] turn
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int idle_cycles;
  bit calm;   // set for the tail of the run: no gaps, no stalls

  joystick_deadzone_velocity_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  jdvm_velocity_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: any accepted request on either side clears the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("joystick_deadzone_velocity_map test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: ready bursts with random stalls, none once calm.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // One register write; caller sits on a rising edge, returns on one.
  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [4:0] bits, logic [15:0] dz, logic [1:0] layout,
                                logic [LIMIT_W-1:0] fwd, logic [LIMIT_W-1:0] lat,
                                logic [LIMIT_W-1:0] turn, logic [2:0] signs);
    write_reg(REG_AXIS_BITS, CFG_DATA_W'(bits));
    write_reg(REG_DEADZONE, CFG_DATA_W'(dz));
    write_reg(REG_LAYOUT, CFG_DATA_W'(layout));
    write_reg(REG_FWD_LIMIT, fwd);
    write_reg(REG_LAT_LIMIT, lat);
    write_reg(REG_TURN_LIMIT, turn);
    write_reg(REG_SIGN_MASK, CFG_DATA_W'(signs));
    cfg_we <= 1'b0;
  endtask

  // Hold a request until the block takes it; an optional gap goes first.
  task automatic send_request(logic func, logic [7:0] num, logic [15:0] value);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= IN_DATA_W'({value, num});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic axis_event(logic [7:0] num, logic [15:0] value);
    send_request(FUNC_EVENT, num, value);
  endtask

  task automatic read_request();
    send_request(FUNC_READ, 8'($urandom_range(0, 255)), 16'($urandom));
  endtask

  // Wait for every predicted command, then let any result-less read finish.
  task automatic drain_and_pause();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return LIMIT_FULL;
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [4:0]  bits;
    logic [15:0] dz;
    logic [1:0]  layout;
    logic [7:0]  num;
    calm      = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= FUNC_EVENT;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_AXIS_BITS;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // -- directed part --
    // reset layout is off: a read gives nothing
    read_request();
    drain_and_pause();

    // full-scale axes, both signs, zero and smallest step
    apply_settings(5'd16, 16'd0, LAYOUT_012, LIMIT_FULL, LIMIT_FULL, LIMIT_FULL, 3'd0);
    axis_event(8'd0, 16'h7FFF);
    axis_event(8'd1, 16'h8000);
    axis_event(8'd2, 16'h0000);
    axis_event(8'd3, 16'h0001);
    read_request();
    axis_event(8'd0, 16'h8000);
    axis_event(8'd1, 16'h7FFF);
    axis_event(8'd2, 16'hFFFF);
    read_request();
    // axis numbers beyond the table are dropped
    axis_event(8'd8, 16'h1234);
    axis_event(8'd255, 16'hFFFB);
    read_request();
    drain_and_pause();

    // second layout, widest deadzone, all directions negated, coarsest resolution
    apply_settings(5'd2, DZ_MAX, LAYOUT_013, '0, 24'd1, 24'h800000, 3'd7);
    axis_event(8'd3, 16'hFFFE);
    axis_event(8'd0, 16'h0001);
    read_request();
    axis_event(8'd1, 16'hFFFF);
    read_request();
    drain_and_pause();

    // out-of-range resolution and deadzone get clamped by the block
    apply_settings(5'd31, 16'hFFFF, LAYOUT_012, LIMIT_FULL, 24'h010000, LIMIT_FULL, 3'd2);
    axis_event(8'd0, 16'h4000);
    axis_event(8'd2, 16'h8000);
    read_request();
    drain_and_pause();
    apply_settings(5'd0, 16'd100, LAYOUT_012, 24'h123456, LIMIT_FULL, 24'h000001, 3'd5);
    read_request();
    drain_and_pause();

    // layout off and the reserved code: reads dropped, events still stored
    apply_settings(5'd30, 16'd0, LAYOUT_OFF, LIMIT_FULL, LIMIT_FULL, LIMIT_FULL, 3'd0);
    read_request();
    axis_event(8'd7, 16'h7FFF);
    drain_and_pause();
    apply_settings(5'd17, 16'd0, LAYOUT_RESERVED, LIMIT_FULL, LIMIT_FULL, LIMIT_FULL, 3'd1);
    axis_event(8'd4, 16'hFF9C);
    read_request();
    drain_and_pause();

    // -- random part: fresh settings per phase, last phase without gaps or stalls --
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       bits = BITS_MIN;
        1:       bits = BITS_MAX;
        2:       bits = 5'($urandom_range(0, 31));
        3:       bits = 5'd16;
        default: bits = 5'($urandom_range(2, 17));
      endcase
      case ($urandom_range(0, 4))
        0:       dz = '0;
        1:       dz = DZ_MAX;
        2:       dz = 16'($urandom);
        default: dz = 16'($urandom_range(0, 40000));
      endcase
      case ($urandom_range(0, 9))
        0:       layout = LAYOUT_OFF;
        1:       layout = LAYOUT_RESERVED;
        2, 3, 4: layout = LAYOUT_013;
        default: layout = LAYOUT_012;
      endcase
      if (phase == RANDOM_PHASES - 1) begin
        calm   = 1'b1;
        layout = LAYOUT_012;
      end
      apply_settings(bits, dz, layout, pick_limit(), pick_limit(), pick_limit(),
                     3'($urandom_range(0, 7)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 6) begin
          // mostly axes in the table, now and then any number
          num = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, AXIS_COUNT - 1));
          axis_event(num, pick_value());
        end else begin
          read_request();
        end
      end
      drain_and_pause();
    end

    if (fail_count == 0) begin
      $display("joystick_deadzone_velocity_map test passed");
    end else begin
      $display("joystick_deadzone_velocity_map test failed");
    end
    $finish;
  end

endmodule
